// ===== hdl/yuvrgb_pkg.sv =====
// Package for the YUY2 macropixel to RGB converter.
// Holds the item structs, register map codes and register reset values.
// No dependencies.
`default_nettype none

package yuvrgb_pkg;

  // One input item: a YUY2 macropixel, byte 0 first
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_u;
    logic [7:0] luma_second;
    logic [7:0] chroma_v;
  } in_item_t;

  // One result item: two RGB pixels
  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
  } out_item_t;

  // Register map, one 32-bit word per register
  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgIdxWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegLumaOffset   = 3'd0,
    RegChromaOffset = 3'd1,
    RegLumaGain     = 3'd2,
    RegBlueUGain    = 3'd3,
    RegGreenUGain   = 3'd4,
    RegGreenVGain   = 3'd5,
    RegRedVGain     = 3'd6
  } cfg_reg_e;

  // Reset values (BT.601 studio range, gains scaled by 64)
  localparam logic [7:0]  LumaOffsetRst   = 8'd16;
  localparam logic [7:0]  ChromaOffsetRst = 8'd128;
  localparam logic [15:0] LumaGainRst     = 16'd74;
  localparam logic [15:0] BlueUGainRst    = 16'd129;
  localparam logic [15:0] GreenUGainRst   = 16'd25;
  localparam logic [15:0] GreenVGainRst   = 16'd52;
  localparam logic [15:0] RedVGainRst     = 16'd102;

endpackage

`default_nettype wire

// ===== hdl/yuv422_macropixel_to_rgb.sv =====
// YUY2 macropixel to two RGB pixels, 16-bit fixed-point datapath.
// Depends on yuvrgb_pkg (item structs, register map, reset values).
// Three register stages: input, products, result.
`default_nettype none

// Usage: one macropixel is taken at each clock edge where start is high;
// busy is always low, so a new item may enter every cycle. The result for
// an item appears on result_o with result_strobe_o high for exactly one
// cycle, after it has passed the input register, the product register of
// the six 16x16 multipliers and the result register. The receiver
// cannot hold results off: it must take each one in its strobe cycle.
// Write the configuration registers over APB only while no item is in
// flight; a write lands at the edge where psel, penable, pwrite and
// pready are high, pready being always high.
module yuv422_macropixel_to_rgb #(
  parameter int unsigned SCALE_SHIFT = 6
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // item channel
  input  wire                                   start,
  output logic                                  busy,
  input  yuvrgb_pkg::in_item_t                  in_item_i,
  output logic                                  result_strobe_o,
  output yuvrgb_pkg::out_item_t                 result_o,
  // APB configuration port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire [yuvrgb_pkg::CfgAddrWidth-1:0]    paddr,
  input  wire [31:0]                            pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  // ---------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------

  // Offset removal: 9-bit signed difference, never overflows
  function automatic logic signed [8:0] sub_off(input logic [7:0] x, input logic [7:0] off);
    sub_off = $signed({1'b0, x}) - $signed({1'b0, off});
  endfunction

  // Low 16 bits of signed product, read as signed
  function automatic logic signed [15:0] mul_lo16(input logic signed [8:0] a,
                                                  input logic [15:0] g);
    logic signed [15:0] a16;
    logic signed [31:0] p;
    a16 = {{7{a[8]}}, a};
    p = a16 * $signed(g);
    mul_lo16 = p[15:0];
  endfunction

  // Saturating 16-bit add or subtract
  function automatic logic signed [15:0] addsub_sat16(input logic signed [15:0] a,
                                                      input logic signed [15:0] b,
                                                      input logic sub);
    logic signed [16:0] s;
    s = sub ? ({a[15], a} - {b[15], b}) : ({a[15], a} + {b[15], b});
    if (s[16] != s[15]) begin
      addsub_sat16 = s[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      addsub_sat16 = s[15:0];
    end
  endfunction

  // Arithmetic shift by the scale, then clamp to 0..255
  function automatic logic [7:0] shift_clamp(input logic signed [15:0] v);
    logic signed [15:0] sh;
    sh = v >>> SCALE_SHIFT;
    if (sh[15]) begin
      shift_clamp = 8'd0;
    end else if (sh[14:8] != '0) begin
      shift_clamp = 8'hff;
    end else begin
      shift_clamp = sh[7:0];
    end
  endfunction

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [7:0]  luma_off_q, chroma_off_q;
  logic [15:0] luma_gain_q, blue_u_gain_q, green_u_gain_q, green_v_gain_q, red_v_gain_q;
  logic        cfg_wr;
  yuvrgb_pkg::cfg_reg_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = yuvrgb_pkg::cfg_reg_e'(paddr[yuvrgb_pkg::CfgAddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_off_q     <= yuvrgb_pkg::LumaOffsetRst;
      chroma_off_q   <= yuvrgb_pkg::ChromaOffsetRst;
      luma_gain_q    <= yuvrgb_pkg::LumaGainRst;
      blue_u_gain_q  <= yuvrgb_pkg::BlueUGainRst;
      green_u_gain_q <= yuvrgb_pkg::GreenUGainRst;
      green_v_gain_q <= yuvrgb_pkg::GreenVGainRst;
      red_v_gain_q   <= yuvrgb_pkg::RedVGainRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        yuvrgb_pkg::RegLumaOffset:   luma_off_q     <= pwdata[7:0];
        yuvrgb_pkg::RegChromaOffset: chroma_off_q   <= pwdata[7:0];
        yuvrgb_pkg::RegLumaGain:     luma_gain_q    <= pwdata[15:0];
        yuvrgb_pkg::RegBlueUGain:    blue_u_gain_q  <= pwdata[15:0];
        yuvrgb_pkg::RegGreenUGain:   green_u_gain_q <= pwdata[15:0];
        yuvrgb_pkg::RegGreenVGain:   green_v_gain_q <= pwdata[15:0];
        yuvrgb_pkg::RegRedVGain:     red_v_gain_q   <= pwdata[15:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (cfg_idx)
      yuvrgb_pkg::RegLumaOffset:   prdata = {24'd0, luma_off_q};
      yuvrgb_pkg::RegChromaOffset: prdata = {24'd0, chroma_off_q};
      yuvrgb_pkg::RegLumaGain:     prdata = {16'd0, luma_gain_q};
      yuvrgb_pkg::RegBlueUGain:    prdata = {16'd0, blue_u_gain_q};
      yuvrgb_pkg::RegGreenUGain:   prdata = {16'd0, green_u_gain_q};
      yuvrgb_pkg::RegGreenVGain:   prdata = {16'd0, green_v_gain_q};
      yuvrgb_pkg::RegRedVGain:     prdata = {16'd0, red_v_gain_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------
  logic                 in_vld_q;
  yuvrgb_pkg::in_item_t in_q;

  assign busy = 1'b0;  // every cycle takes an item

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: offset removal and the six products
  // ---------------------------------------------------------------
  logic signed [8:0]  y0_off, y1_off, u_off, v_off;
  logic               prod_vld_q;
  logic signed [15:0] y0_d, y1_d, bu_d, gu_d, gv_d, rv_d;
  logic signed [15:0] y0_q, y1_q, bu_q, gu_q, gv_q, rv_q;

  always_comb begin
    y0_off = sub_off(in_q.luma_first, luma_off_q);
    y1_off = sub_off(in_q.luma_second, luma_off_q);
    u_off  = sub_off(in_q.chroma_u, chroma_off_q);
    v_off  = sub_off(in_q.chroma_v, chroma_off_q);
    y0_d   = mul_lo16(y0_off, luma_gain_q);
    y1_d   = mul_lo16(y1_off, luma_gain_q);
    bu_d   = mul_lo16(u_off, blue_u_gain_q);
    gu_d   = mul_lo16(u_off, green_u_gain_q);
    gv_d   = mul_lo16(v_off, green_v_gain_q);
    rv_d   = mul_lo16(v_off, red_v_gain_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      y0_q <= y0_d;
      y1_q <= y1_d;
      bu_q <= bu_d;
      gu_q <= gu_d;
      gv_q <= gv_d;
      rv_q <= rv_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: saturating sums, scale and clamp into the result register
  // ---------------------------------------------------------------
  logic signed [15:0]    guv;
  yuvrgb_pkg::out_item_t res_d, res_q;
  logic                  res_vld_q;

  always_comb begin
    guv = addsub_sat16(gu_q, gv_q, 1'b0);
    res_d.blue_first   = shift_clamp(addsub_sat16(y0_q, bu_q, 1'b0));
    res_d.green_first  = shift_clamp(addsub_sat16(y0_q, guv, 1'b1));
    res_d.red_first    = shift_clamp(addsub_sat16(y0_q, rv_q, 1'b0));
    res_d.blue_second  = shift_clamp(addsub_sat16(y1_q, bu_q, 1'b0));
    res_d.green_second = shift_clamp(addsub_sat16(y1_q, guv, 1'b1));
    res_d.red_second   = shift_clamp(addsub_sat16(y1_q, rv_q, 1'b0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_vld_q) begin
      res_q <= res_d;
    end
  end

  assign result_strobe_o = res_vld_q;
  assign result_o        = res_q;

endmodule

`default_nettype wire

// ===== tb/sv/yuv422_macropixel_to_rgb_test.sv =====
// Self-checking testbench for yuv422_macropixel_to_rgb (YUY2 to RGB).
// Drives macropixels and APB register writes, predicts each RGB pair.
// Depends on yuvrgb_pkg and the converter RTL.
`default_nettype none

module yuv422_macropixel_to_rgb_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ScaleShift     = 6;
  localparam int unsigned RandomPerPhase = 125;
  localparam int unsigned NumPhases      = 12;
  localparam int unsigned NumDirected    = 16;
  // register slot past the end of the map; writes there must be dropped
  localparam logic [yuvrgb_pkg::CfgIdxWidth-1:0] RegUnmapped = 3'd7;

  // directed row: typed expectation flag, macropixel, typed RGB pair
  typedef struct packed {
    logic                  typed;
    yuvrgb_pkg::in_item_t  px;
    yuvrgb_pkg::out_item_t rgb;
  } stim_row_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  yuvrgb_pkg::in_item_t                in_item_i;
  logic                                result_strobe_o;
  yuvrgb_pkg::out_item_t               result_o;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [yuvrgb_pkg::CfgAddrWidth-1:0] paddr;
  logic [31:0]                         pwdata;
  logic [31:0]                         prdata;
  logic                                pready;

  // shadow copy of the register file
  logic [7:0]         luma_ofs_q;
  logic [7:0]         chroma_ofs_q;
  logic signed [15:0] luma_gain_q;
  logic signed [15:0] blue_u_gain_q;
  logic signed [15:0] green_u_gain_q;
  logic signed [15:0] green_v_gain_q;
  logic signed [15:0] red_v_gain_q;

  yuvrgb_pkg::out_item_t pending_rgb[$];
  int unsigned rgb_errors  = 0;
  int unsigned items_sent  = 0;

  // Black, white and luma split rows are typed; the rest go through the predictor.
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{1'b1, '{8'd16, 8'd128, 8'd16, 8'd128}, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b1, '{8'd255, 8'd128, 8'd255, 8'd128},
      '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}},
    '{1'b1, '{8'd0, 8'd128, 8'd255, 8'd128},
      '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255}},
    '{1'b0, '{8'd0, 8'd0, 8'd0, 8'd0}, '0},
    '{1'b0, '{8'd255, 8'd255, 8'd255, 8'd255}, '0},
    '{1'b0, '{8'd128, 8'd0, 8'd128, 8'd255}, '0},
    '{1'b0, '{8'd128, 8'd255, 8'd128, 8'd0}, '0},
    '{1'b0, '{8'd235, 8'd128, 8'd235, 8'd128}, '0},
    '{1'b0, '{8'd16, 8'd240, 8'd16, 8'd16}, '0},
    '{1'b0, '{8'd16, 8'd16, 8'd16, 8'd240}, '0},
    '{1'b0, '{8'hAA, 8'h55, 8'hAA, 8'h55}, '0},
    '{1'b0, '{8'h55, 8'hAA, 8'h55, 8'hAA}, '0},
    '{1'b0, '{8'd81, 8'd90, 8'd145, 8'd240}, '0},
    '{1'b0, '{8'd255, 8'd0, 8'd0, 8'd255}, '0},
    '{1'b0, '{8'd0, 8'd255, 8'd255, 8'd0}, '0},
    '{1'b0, '{8'd1, 8'd127, 8'd254, 8'd129}, '0}
  };

  yuv422_macropixel_to_rgb #(
    .SCALE_SHIFT(ScaleShift)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_item_i      (in_item_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // low 16 bits of a product, read as two's complement
  function automatic int wrap16(input int v);
    return int'($signed(v[15:0]));
  endfunction

  // saturate to 16 bits, arithmetic shift, clamp to a byte
  function automatic logic [7:0] to_channel(input int sum);
    int s;
    int c;
    s = (sum > 32767) ? 32767 : (sum < -32768) ? -32768 : sum;
    c = s >>> ScaleShift;
    if (c < 0) return 8'd0;
    if (c > 255) return 8'd255;
    return c[7:0];
  endfunction

  function automatic yuvrgb_pkg::out_item_t convert_macropixel(input yuvrgb_pkg::in_item_t px);
    yuvrgb_pkg::out_item_t rgb;
    int u_d;
    int v_d;
    int blue_u;
    int red_v;
    int green_uv;
    int luma_a;
    int luma_b;
    u_d      = int'(px.chroma_u) - int'(chroma_ofs_q);
    v_d      = int'(px.chroma_v) - int'(chroma_ofs_q);
    blue_u   = wrap16(u_d * int'(blue_u_gain_q));
    red_v    = wrap16(v_d * int'(red_v_gain_q));
    green_uv = wrap16(u_d * int'(green_u_gain_q)) + wrap16(v_d * int'(green_v_gain_q));
    green_uv = (green_uv > 32767) ? 32767 : (green_uv < -32768) ? -32768 : green_uv;
    luma_a   = wrap16((int'(px.luma_first) - int'(luma_ofs_q)) * int'(luma_gain_q));
    luma_b   = wrap16((int'(px.luma_second) - int'(luma_ofs_q)) * int'(luma_gain_q));
    rgb.blue_first   = to_channel(luma_a + blue_u);
    rgb.green_first  = to_channel(luma_a - green_uv);
    rgb.red_first    = to_channel(luma_a + red_v);
    rgb.blue_second  = to_channel(luma_b + blue_u);
    rgb.green_second = to_channel(luma_b - green_uv);
    rgb.red_second   = to_channel(luma_b + red_v);
    return rgb;
  endfunction

  // biased toward the sample extremes
  function automatic logic [7:0] random_sample();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // half realistic small gains, half anything 16 bits can hold
  function automatic logic [15:0] random_gain();
    int g;
    g = int'($urandom_range(512)) - 256;
    if ($urandom_range(1) == 0) return g[15:0];
    return 16'($urandom);
  endfunction

  // APB write: setup then access; junk above the register width
  task automatic cfg_write(input logic [yuvrgb_pkg::CfgIdxWidth-1:0] idx,
                           input logic [15:0] val);
    logic [31:0] data;
    data = $urandom;
    if (idx == yuvrgb_pkg::RegLumaOffset || idx == yuvrgb_pkg::RegChromaOffset) begin
      data[7:0] = val[7:0];
    end else begin
      data[15:0] = val;
    end
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      yuvrgb_pkg::RegLumaOffset:   luma_ofs_q     = data[7:0];
      yuvrgb_pkg::RegChromaOffset: chroma_ofs_q   = data[7:0];
      yuvrgb_pkg::RegLumaGain:     luma_gain_q    = data[15:0];
      yuvrgb_pkg::RegBlueUGain:    blue_u_gain_q  = data[15:0];
      yuvrgb_pkg::RegGreenUGain:   green_u_gain_q = data[15:0];
      yuvrgb_pkg::RegGreenVGain:   green_v_gain_q = data[15:0];
      yuvrgb_pkg::RegRedVGain:     red_v_gain_q   = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] lo, input logic [7:0] co,
                              input logic [15:0] gy, input logic [15:0] gbu,
                              input logic [15:0] ggu, input logic [15:0] ggv,
                              input logic [15:0] grv);
    cfg_write(RegUnmapped, 16'($urandom));
    cfg_write(yuvrgb_pkg::RegLumaOffset, {8'h00, lo});
    cfg_write(yuvrgb_pkg::RegChromaOffset, {8'h00, co});
    cfg_write(yuvrgb_pkg::RegLumaGain, gy);
    cfg_write(yuvrgb_pkg::RegBlueUGain, gbu);
    cfg_write(yuvrgb_pkg::RegGreenUGain, ggu);
    cfg_write(yuvrgb_pkg::RegGreenVGain, ggv);
    cfg_write(yuvrgb_pkg::RegRedVGain, grv);
  endtask

  // one item; sender idles 35% of cycles first, then 65%, then none
  task automatic send_macropixel(input yuvrgb_pkg::in_item_t px, input logic typed,
                                 input yuvrgb_pkg::out_item_t typed_rgb);
    int unsigned idle_pct;
    idle_pct = (items_sent < 500) ? 35 : (items_sent < 1000) ? 65 : 0;
    @(negedge clk_i);
    // each cycle stays idle at the phase's odds
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start     <= 1'b1;
    in_item_i <= px;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_rgb.push_back(typed ? typed_rgb : convert_macropixel(px));
    items_sent++;
  endtask

  // stop sending and wait for every outstanding RGB pair
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      rgb_errors++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : rgb_monitor
    yuvrgb_pkg::out_item_t want;
    if (rst_ni === 1'b1 && result_strobe_o === 1'b1) begin
      if (pending_rgb.size() == 0) begin
        $error("result_o: unexpected item %h", result_o);
        rgb_errors++;
      end else begin
        want = pending_rgb.pop_front();
        compare_channel("blue_first", want.blue_first, result_o.blue_first);
        compare_channel("green_first", want.green_first, result_o.green_first);
        compare_channel("red_first", want.red_first, result_o.red_first);
        compare_channel("blue_second", want.blue_second, result_o.blue_second);
        compare_channel("green_second", want.green_second, result_o.green_second);
        compare_channel("red_second", want.red_second, result_o.red_second);
      end
    end
  end

  initial begin : stimulus
    yuvrgb_pkg::in_item_t px;
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_item_i = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    luma_ofs_q     = yuvrgb_pkg::LumaOffsetRst;
    chroma_ofs_q   = yuvrgb_pkg::ChromaOffsetRst;
    luma_gain_q    = yuvrgb_pkg::LumaGainRst;
    blue_u_gain_q  = yuvrgb_pkg::BlueUGainRst;
    green_u_gain_q = yuvrgb_pkg::GreenUGainRst;
    green_v_gain_q = yuvrgb_pkg::GreenVGainRst;
    red_v_gain_q   = yuvrgb_pkg::RedVGainRst;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          // reset settings: walk the directed table first
          for (int r = 0; r < NumDirected; r++) begin
            send_macropixel(DirectedRows[r].px, DirectedRows[r].typed, DirectedRows[r].rgb);
          end
        end
        // every register at its top, then at its bottom
        1: apply_config(8'd255, 8'd255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        2: apply_config(8'd0, 8'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        // grayscale: unit luma gain, chroma ignored
        3: apply_config(8'd16, 8'd128, 16'd64, 16'd0, 16'd0, 16'd0, 16'd0);
        // opposing extremes to force product wrap and sum saturation
        4: apply_config(8'd0, 8'd255, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        NumPhases - 1: apply_config(yuvrgb_pkg::LumaOffsetRst, yuvrgb_pkg::ChromaOffsetRst,
                                    yuvrgb_pkg::LumaGainRst, yuvrgb_pkg::BlueUGainRst,
                                    yuvrgb_pkg::GreenUGainRst, yuvrgb_pkg::GreenVGainRst,
                                    yuvrgb_pkg::RedVGainRst);
        default: apply_config(8'($urandom), 8'($urandom), random_gain(), random_gain(),
                              random_gain(), random_gain(), random_gain());
      endcase
      repeat (RandomPerPhase) begin
        px.luma_first  = random_sample();
        px.chroma_u    = random_sample();
        px.luma_second = random_sample();
        px.chroma_v    = random_sample();
        send_macropixel(px, 1'b0, '0);
      end
      drain_results();
    end

    // pipeline is three stages deep; keep watching for strays before the verdict
    repeat (10) @(posedge clk_i);
    if (rgb_errors == 0 && pending_rgb.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
